// ===== design/prt_pkg.sv =====
// shared types, constants and codes for the peer record table
package prt_pkg;

  localparam int TableSlots  = 128;
  localparam int ModeBits    = 32;
  localparam int BodyBits    = 64;
  localparam int RecordLimit = 100;
  localparam int SlotW       = $clog2(TableSlots);
  localparam int CountW      = $clog2(TableSlots + 1);
  localparam int BitsW       = $clog2(ModeBits + 1);
  localparam logic [15:0] GoodPreamble = 16'h5350;
  localparam logic [7:0]  GoodVersion  = 8'h00;
  localparam logic [CountW-1:0] Limit =
      CountW'((RecordLimit < TableSlots) ? RecordLimit : TableSlots);

  localparam logic [1:0] OpRecv   = 2'd0;
  localparam logic [1:0] OpMark   = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [0:0] CfgEnable = 1'd0;
  localparam logic [0:0] CfgLength = 1'd1;

  typedef enum logic [3:0] {
    StDisabled  = 4'd0,
    StRejected  = 4'd1,
    StRewritten = 4'd2,
    StUnchanged = 4'd3,
    StInserted  = 4'd4,
    StEvicted   = 4'd5,
    StDropped   = 4'd6,
    StMarkChg   = 4'd7,
    StMarkSame  = 4'd8,
    StRead      = 4'd9,
    StBadSlot   = 4'd10
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] peer_address;
    logic [7:0]  packet_length;
    logic [15:0] packet_preamble;
    logic [7:0]  packet_version;
    logic [63:0] packet_body;
    logic [6:0]  entry_index;
    logic [4:0]  mode_index;
    logic        mark_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [6:0]  slot;
    logic        store_write;
    logic        store_erase;
    logic [47:0] erased_address;
    logic        entry_valid;
    logic [47:0] entry_address;
    logic [63:0] entry_body;
    logic [31:0] entry_mask;
    logic        mode_used;
  } out_item_t;

  typedef enum logic [3:0] {
    SIdle, SDecode, SScanRd, SScan, SScanEnd, SEvict, SFree, SWrite, SRdWait, SOpDone,
    SOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_clr;   // reset scan registers and address
    logic scan_rd;    // issue read at scan address
    logic scan_step;  // evaluate read data and advance
    logic rd_idx;     // read at entry index
    logic evict;      // invalidate victim
    logic ins;        // write new record at free slot
    logic rewrite;    // rewrite matching slot
    logic mark;       // apply mark to entry index
    logic fin;        // build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_recv;
    logic op_mark;
    logic op_read;
    logic header_ok;
    logic idx_ok;
    logic scan_last;
    logic hit;
    logic full;
    logic have_victim;
    logic have_free;
  } sts_t;

  function automatic logic [BitsW-1:0] popcount(input logic [ModeBits-1:0] v);
    logic [BitsW-1:0] n;
    n = '0;
    for (int i = 0; i < ModeBits; i++) n = n + BitsW'(v[i]);
    return n;
  endfunction

endpackage

// ===== design/prt_ctrl.sv =====
// controller state machine sequencing the slot scan and table updates
module prt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  logic           enabled_i,
  input  prt_pkg::sts_t  sts_i,
  output prt_pkg::cmd_t  cmd_o
);
  import prt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (in_valid_i) state_d = SDecode;
      SDecode: begin
        if (sts_i.op_recv) begin
          state_d = (enabled_i && sts_i.header_ok) ? SScanRd : SOpDone;
        end else if ((sts_i.op_mark || sts_i.op_read) && sts_i.idx_ok) begin
          state_d = SRdWait;
        end else begin
          state_d = SOpDone;
        end
      end
      SScanRd: state_d = SScan;
      SScan: begin
        if (sts_i.hit) state_d = SWrite;
        else if (sts_i.scan_last) state_d = SScanEnd;
        else state_d = SScan;
      end
      SScanEnd: begin
        // a hit on the last slot shows up only here
        if (sts_i.hit) state_d = SWrite;
        else if (sts_i.full) state_d = sts_i.have_victim ? SEvict : SOpDone;
        else state_d = SFree;
      end
      SEvict:  state_d = SFree;
      SFree:   state_d = SWrite;
      SWrite:  state_d = SOpDone;
      SRdWait: state_d = SOpDone;
      SOpDone: state_d = SOut;
      SOut:    if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      SDecode: begin
        cmd_o.scan_clr = 1'b1;
        cmd_o.rd_idx   = 1'b1;
      end
      SScanRd: cmd_o.scan_rd = 1'b1;
      SScan: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_rd   = 1'b1;
      end
      SEvict: cmd_o.evict = 1'b1;
      SWrite: begin
        cmd_o.ins     = !sts_i.hit;
        cmd_o.rewrite = sts_i.hit;
      end
      SRdWait: cmd_o.mark = sts_i.op_mark;
      SOpDone: cmd_o.fin = 1'b1;
      SOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/prt_dpath.sv =====
// datapath: record memory, scan registers, victim and free-slot search, result
module prt_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prt_pkg::in_item_t  in_data_i,
  input  logic               enabled_i,
  input  logic [7:0]         exp_len_i,
  input  prt_pkg::cmd_t      cmd_i,
  output prt_pkg::sts_t      sts_o,
  output prt_pkg::out_item_t out_data_o
);
  import prt_pkg::*;

  // record memory: one read port, one write port
  logic [47:0]         key_mem   [TableSlots];
  logic [BodyBits-1:0] body_mem  [TableSlots];
  logic [ModeBits-1:0] mask_mem  [TableSlots];
  logic [31:0]         stamp_mem [TableSlots];
  logic [TableSlots-1:0] valid_q;

  in_item_t item_q;
  logic [SlotW-1:0] raddr, waddr;
  logic [SlotW-1:0] rslot_q;
  logic [47:0] rkey_q;
  logic [BodyBits-1:0] rbody_q;
  logic [ModeBits-1:0] rmask_q;
  logic [31:0] rstamp_q;
  logic we;
  logic [47:0] wkey;
  logic [BodyBits-1:0] wbody;
  logic [ModeBits-1:0] wmask;
  logic wstamp_en;

  logic [SlotW-1:0] scan_q;
  logic [SlotW:0]   scan_cnt_q;
  logic             hit_q, changed_q, have_victim_q, have_free_q, inserted_q, evicted_q;
  logic [SlotW-1:0] hit_slot_q, victim_q, free_q;
  logic [BitsW-1:0] best_bits_q;
  logic [31:0]      best_age_q;
  logic [47:0]      victim_key_q;
  logic [CountW-1:0] count_q;
  logic [31:0]      stamp_q;
  out_item_t        res_q;

  logic [ModeBits-1:0] bit_sel;
  logic [SlotW-1:0]    idx_slot;
  logic [BodyBits-1:0] new_body;
  logic                cur_valid, cur_match;
  logic [BitsW-1:0]    cur_bits;
  logic [31:0]         cur_age;
  logic                mark_want;

  assign idx_slot = SlotW'(item_q.entry_index);
  assign new_body = item_q.packet_body[BodyBits-1:0];
  assign bit_sel  = ({27'd0, item_q.mode_index} < 32'(ModeBits))
                    ? ModeBits'(1) << item_q.mode_index : '0;

  always_comb begin
    raddr = scan_q;
    if (cmd_i.rd_idx) raddr = idx_slot;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_idx || cmd_i.scan_rd) begin
      rslot_q  <= raddr;
      rkey_q   <= key_mem[raddr];
      rbody_q  <= body_mem[raddr];
      rmask_q  <= mask_mem[raddr];
      rstamp_q <= stamp_mem[raddr];
    end
    if (we) begin
      key_mem[waddr]  <= wkey;
      body_mem[waddr] <= wbody;
      mask_mem[waddr] <= wmask;
      if (wstamp_en) stamp_mem[waddr] <= stamp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  assign cur_valid = valid_q[rslot_q];
  assign cur_match = cur_valid && (rkey_q == item_q.peer_address);
  assign cur_bits  = popcount(rmask_q);
  assign cur_age   = stamp_q - rstamp_q;
  assign mark_want = item_q.mark_value;

  // write port
  always_comb begin
    we = 1'b0; waddr = free_q; wkey = item_q.peer_address;
    wbody = new_body; wmask = '0; wstamp_en = 1'b0;
    if (cmd_i.ins) begin
      we = have_free_q; wstamp_en = 1'b1;
    end else if (cmd_i.rewrite) begin
      we = changed_q;
      waddr = hit_slot_q;
    end else if (cmd_i.mark) begin
      we = valid_q[idx_slot]; waddr = idx_slot;
      wkey = rkey_q; wbody = rbody_q;
      wmask = mark_want ? (rmask_q | bit_sel) : (rmask_q & ~bit_sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      count_q  <= '0;
      stamp_q  <= '0;
      scan_q   <= '0;
      scan_cnt_q <= '0;
      hit_q    <= 1'b0;
      have_victim_q <= 1'b0;
      have_free_q   <= 1'b0;
      inserted_q    <= 1'b0;
      evicted_q     <= 1'b0;
      changed_q     <= 1'b0;
    end else begin
      if (cmd_i.scan_clr) begin
        scan_q <= '0; scan_cnt_q <= '0; hit_q <= 1'b0; have_victim_q <= 1'b0;
        have_free_q <= 1'b0; inserted_q <= 1'b0; evicted_q <= 1'b0; changed_q <= 1'b0;
      end
      if (cmd_i.scan_rd && !cmd_i.scan_step) scan_q <= scan_q + SlotW'(1);
      if (cmd_i.scan_step) begin
        scan_q     <= scan_q + SlotW'(1);
        scan_cnt_q <= scan_cnt_q + (SlotW+1)'(1);
        if (cur_match) begin
          hit_q     <= 1'b1;
          // decided on the matching slot's read data, which the scan overwrites
          changed_q <= (rbody_q != new_body) || (rmask_q != '0);
        end else if (cur_valid) begin
          if (cur_bits > best_bits_q ||
              (cur_bits == best_bits_q && cur_bits != '0 && have_victim_q &&
               cur_age > best_age_q)) begin
            have_victim_q <= 1'b1;
          end
        end else if (!have_free_q) begin
          have_free_q <= 1'b1;
        end
      end
      if (cmd_i.evict) begin
        valid_q[victim_q] <= 1'b0;
        count_q <= count_q - CountW'(1);
        evicted_q <= 1'b1;
        // evicted slot may be below the first free one
        if (!have_free_q || victim_q < free_q) have_free_q <= 1'b1;
      end
      if (cmd_i.ins && have_free_q) begin
        valid_q[free_q] <= 1'b1;
        count_q <= count_q + CountW'(1);
        stamp_q <= stamp_q + 32'd1;
        inserted_q <= 1'b1;
      end
      if (cmd_i.mark) changed_q <= ((rmask_q & bit_sel) != '0) != mark_want && (bit_sel != '0);
    end
  end

  // payload registers of the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      best_bits_q <= '0; best_age_q <= '0;
    end
    if (cmd_i.scan_step) begin
      if (cur_match) begin
        hit_slot_q <= rslot_q;
      end else if (cur_valid) begin
        if (cur_bits > best_bits_q ||
            (cur_bits == best_bits_q && cur_bits != '0 && have_victim_q &&
             cur_age > best_age_q)) begin
          best_bits_q  <= cur_bits;
          best_age_q   <= cur_age;
          victim_q     <= rslot_q;
          victim_key_q <= rkey_q;
        end
      end else if (!have_free_q) begin
        free_q <= rslot_q;
      end
    end
    if (cmd_i.evict && (!have_free_q || victim_q < free_q)) free_q <= victim_q;
  end

  // result
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q <= '0;
      if (item_q.op == OpRecv) begin
        if (!enabled_i) begin
          res_q.status <= StDisabled;
        end else if (item_q.packet_length != exp_len_i ||
                     item_q.packet_preamble != GoodPreamble ||
                     item_q.packet_version != GoodVersion) begin
          res_q.status <= StRejected;
        end else if (hit_q) begin
          res_q.status        <= changed_q ? StRewritten : StUnchanged;
          res_q.store_write   <= changed_q;
          res_q.slot          <= 7'(hit_slot_q);
          res_q.entry_valid   <= 1'b1;
          res_q.entry_address <= item_q.peer_address;
          res_q.entry_body    <= 64'(new_body);
        end else if (inserted_q) begin
          res_q.status         <= evicted_q ? StEvicted : StInserted;
          res_q.store_erase    <= evicted_q;
          res_q.erased_address <= evicted_q ? victim_key_q : '0;
          res_q.store_write    <= 1'b1;
          res_q.slot           <= 7'(free_q);
          res_q.entry_valid    <= 1'b1;
          res_q.entry_address  <= item_q.peer_address;
          res_q.entry_body     <= 64'(new_body);
        end else begin
          res_q.status <= StDropped;
        end
      end else if (item_q.op == OpMark || item_q.op == OpRead) begin
        if ({1'b0, item_q.entry_index} >= 8'(TableSlots)) begin
          res_q.status <= StBadSlot;
          res_q.slot   <= item_q.entry_index;
        end else if (!valid_q[idx_slot]) begin
          res_q.status <= (item_q.op == OpRead) ? StRead : StBadSlot;
          res_q.slot   <= item_q.entry_index;
        end else begin
          res_q.slot          <= item_q.entry_index;
          res_q.entry_valid   <= 1'b1;
          res_q.entry_address <= rkey_q;
          res_q.entry_body    <= 64'(rbody_q);
          res_q.mode_used     <= (rmask_q & bit_sel) != '0;
          if (item_q.op == OpRead) begin
            res_q.status     <= StRead;
            res_q.entry_mask <= 32'(rmask_q);
          end else begin
            res_q.status      <= changed_q ? StMarkChg : StMarkSame;
            res_q.store_write <= changed_q;
            res_q.entry_mask  <= 32'(mark_want ? (rmask_q | bit_sel) : (rmask_q & ~bit_sel));
          end
        end
      end else begin
        res_q.status <= StRejected;
      end
    end
  end

  assign out_data_o = res_q;

  always_comb begin
    sts_o             = '0;
    sts_o.op_recv     = item_q.op == OpRecv;
    sts_o.op_mark     = item_q.op == OpMark;
    sts_o.op_read     = item_q.op == OpRead;
    sts_o.header_ok   = item_q.packet_length == exp_len_i &&
                        item_q.packet_preamble == GoodPreamble &&
                        item_q.packet_version == GoodVersion;
    sts_o.idx_ok      = {1'b0, item_q.entry_index} < 8'(TableSlots);
    sts_o.scan_last   = scan_cnt_q == (SlotW+1)'(TableSlots - 1);
    sts_o.hit         = hit_q;
    sts_o.full        = count_q >= Limit;
    sts_o.have_victim = have_victim_q;
    sts_o.have_free   = have_free_q;
  end

endmodule

// ===== design/peer_record_table_with_usage_eviction_core.sv =====
// peer record table: config registers, controller and datapath
// receive: the result follows a one-slot-per-cycle scan of all 128 slots and, if the
//   table is full, an eviction; a key hit ends the scan early
// mark/read: decode, entry read, result; disabled/rejected/unused op: decode, result
// one transaction at a time; the next is accepted the cycle after the result is taken
// reset clears slot valid bits, entry count, stamp counter and config; no clearing pass
module peer_record_table_with_usage_eviction_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  prt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output prt_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import prt_pkg::*;

  logic       enabled_q;
  logic [7:0] exp_len_q;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      exp_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgEnable: enabled_q <= cfg_data_i[0];
        CfgLength: exp_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  prt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .enabled_i(enabled_q), .sts_i(sts), .cmd_o(cmd)
  );

  prt_dpath u_dpath (
    .clk_i, .rst_ni, .in_data_i, .enabled_i(enabled_q), .exp_len_i(exp_len_q),
    .cmd_i(cmd), .sts_o(sts), .out_data_o
  );

endmodule

// ===== design/prt_checker.sv =====
// port-level checker for the peer record table, bound to the top level
module prt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input prt_pkg::out_item_t out_data_o
);
  import prt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result waits");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= 4'd10)
    else $error("status code out of range");

  a_erase_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.store_erase |-> out_data_o.store_write)
    else $error("erase without write");

endmodule

bind peer_record_table_with_usage_eviction_core prt_checker u_prt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// ===== bench/tb_peer_record_table_with_usage_eviction_core.sv =====
// testbench for the peer record table: random and directed ops checked against a table model
`timescale 1ns / 1ps

module tb_peer_record_table_with_usage_eviction_core;
  import prt_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  peer_record_table_with_usage_eviction_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // table model
  logic        tbl_valid [TableSlots];
  logic [47:0] tbl_key   [TableSlots];
  logic [63:0] tbl_body  [TableSlots];
  logic [31:0] tbl_mask  [TableSlots];
  logic [31:0] tbl_stamp [TableSlots];
  int          tbl_count;
  logic [31:0] stamp_next;
  logic        rx_enabled;
  logic [7:0]  rx_length;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_off;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t record_of(int s, out_item_t r);
    r.slot          = 7'(s);
    r.entry_valid   = 1'b1;
    r.entry_address = tbl_key[s];
    r.entry_body    = tbl_body[s];
    r.entry_mask    = tbl_mask[s];
    return r;
  endfunction

  function automatic int ones(logic [31:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) n += v[i];
    return n;
  endfunction

  function automatic out_item_t predict_table_op(in_item_t it);
    out_item_t r;
    int        best_bits;
    int        victim;
    int        s;
    int        bits;
    logic [31:0] best_age;
    logic [31:0] age;
    logic [31:0] bit_sel;
    logic [31:0] want;
    logic      found;
    r = '0;
    if (it.op == OpRecv) begin
      if (!rx_enabled) begin
        r.status = StDisabled;
        return r;
      end
      if (it.packet_length != rx_length || it.packet_preamble != GoodPreamble ||
          it.packet_version != GoodVersion) begin
        r.status = StRejected;
        return r;
      end
      best_bits = 0;
      best_age  = '0;
      victim    = -1;
      for (s = 0; s < TableSlots; s++) begin
        if (!tbl_valid[s]) continue;
        if (tbl_key[s] == it.peer_address) begin
          if (tbl_body[s] != it.packet_body || tbl_mask[s] != '0) begin
            tbl_body[s]   = it.packet_body;
            tbl_mask[s]   = '0;
            r.status      = StRewritten;
            r.store_write = 1'b1;
          end else begin
            r.status = StUnchanged;
          end
          return record_of(s, r);
        end
        bits = ones(tbl_mask[s]);
        age  = stamp_next - tbl_stamp[s];
        if (bits > best_bits || (bits == best_bits && bits > 0 && victim >= 0 &&
            age > best_age)) begin
          best_bits = bits;
          best_age  = age;
          victim    = s;
        end
      end
      r.status = StInserted;
      if (tbl_count >= int'(Limit)) begin
        if (victim < 0) begin
          r.status = StDropped;
          return r;
        end
        tbl_valid[victim] = 1'b0;
        tbl_count--;
        r.status         = StEvicted;
        r.store_erase    = 1'b1;
        r.erased_address = tbl_key[victim];
      end
      found = 1'b0;
      for (s = 0; s < TableSlots; s++) begin
        if (!tbl_valid[s]) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        r = '0;
        r.status = StDropped;
        return r;
      end
      tbl_valid[s] = 1'b1;
      tbl_key[s]   = it.peer_address;
      tbl_body[s]  = it.packet_body;
      tbl_mask[s]  = '0;
      tbl_stamp[s] = stamp_next;
      stamp_next++;
      tbl_count++;
      r.store_write = 1'b1;
      return record_of(s, r);
    end
    if (it.op == OpUnused) begin
      r.status = StRejected;
      return r;
    end
    s = int'(it.entry_index);
    if (!tbl_valid[s]) begin
      r.status = (it.op == OpRead) ? StRead : StBadSlot;
      r.slot   = it.entry_index;
      return r;
    end
    bit_sel     = 32'd1 << it.mode_index;
    r.mode_used = (tbl_mask[s] & bit_sel) != '0;
    if (it.op == OpRead) begin
      r.status = StRead;
    end else begin
      want = it.mark_value ? bit_sel : '0;
      if ((tbl_mask[s] & bit_sel) != want) begin
        tbl_mask[s]   = (tbl_mask[s] & ~bit_sel) | want;
        r.status      = StMarkChg;
        r.store_write = 1'b1;
      end else begin
        r.status = StMarkSame;
      end
    end
    return record_of(s, r);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items[0];
        expected_results.push_back(predict_table_op(pending_items.pop_front()));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_data.status), '0);
      end else begin
        e = expected_results.pop_front();
        if (out_data.status != e.status) report_mismatch("status", out_data.status, e.status);
        if (out_data.slot != e.slot) report_mismatch("slot", out_data.slot, e.slot);
        if (out_data.store_write != e.store_write)
          report_mismatch("store_write", out_data.store_write, e.store_write);
        if (out_data.store_erase != e.store_erase)
          report_mismatch("store_erase", out_data.store_erase, e.store_erase);
        if (out_data.erased_address != e.erased_address)
          report_mismatch("erased_address", out_data.erased_address, e.erased_address);
        if (out_data.entry_valid != e.entry_valid)
          report_mismatch("entry_valid", out_data.entry_valid, e.entry_valid);
        if (out_data.entry_address != e.entry_address)
          report_mismatch("entry_address", out_data.entry_address, e.entry_address);
        if (out_data.entry_body != e.entry_body)
          report_mismatch("entry_body", out_data.entry_body, e.entry_body);
        if (out_data.entry_mask != e.entry_mask)
          report_mismatch("entry_mask", out_data.entry_mask, e.entry_mask);
        if (out_data.mode_used != e.mode_used)
          report_mismatch("mode_used", out_data.mode_used, e.mode_used);
      end
    end
    if (cycles > 2_000_000) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // small key pool so that hits, rewrites and evictions are frequent
  logic [47:0] key_pool[160];

  function automatic in_item_t make_item(logic [1:0] op);
    in_item_t it;
    it                 = '0;
    it.op              = op;
    it.peer_address    = key_pool[$urandom_range(159)];
    it.packet_length   = rx_length;
    it.packet_preamble = GoodPreamble;
    it.packet_version  = GoodVersion;
    it.packet_body     = ($urandom_range(1)) ? rand64() : 64'(key_pool[0][3:0]);
    it.entry_index     = 7'($urandom_range(127));
    it.mode_index      = 5'($urandom);
    it.mark_value      = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_random();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 45) it = make_item(OpRecv);
    else if (pick < 80) it = make_item(OpMark);
    else if (pick < 94) it = make_item(OpRead);
    else if (pick < 96) it = make_item(OpUnused);
    else begin
      it = make_item(OpRecv);
      case ($urandom_range(2))
        0: it.packet_length = 8'($urandom);
        1: it.packet_preamble = 16'($urandom);
        default: it.packet_version = 8'($urandom_range(255, 1));
      endcase
    end
    // mostly point marks and reads at slots that can be filled
    if (it.op != OpRecv && $urandom_range(9) != 0)
      it.entry_index = 7'($urandom_range(int'(Limit) - 1));
    return it;
  endfunction

  task automatic drain(int settle);
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CfgEnable) rx_enabled = val[0];
    else rx_length = val;
  endtask

  initial begin
    in_item_t it;
    errors        = 0;
    cycles        = 0;
    hold_off      = 0;
    send_idle_pct = 18;
    recv_idle_pct = 58;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    rx_enabled    = 1'b0;
    rx_length     = '0;
    tbl_count     = 0;
    stamp_next    = '0;
    for (int i = 0; i < TableSlots; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_body[i]  = '0;
      tbl_mask[i]  = '0;
      tbl_stamp[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 160; i++) key_pool[i] = 48'(rand64());
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: disabled receive, then extremes and corner cases
    it = make_item(OpRecv);
    pending_items.push_back(it);
    it = make_item(OpUnused);
    pending_items.push_back(it);
    it = make_item(OpRead);
    it.entry_index = 7'd127;
    pending_items.push_back(it);
    it = make_item(OpMark);
    it.entry_index = 7'd0;
    pending_items.push_back(it);
    drain(150);
    write_reg(CfgEnable, 8'd1);
    write_reg(CfgLength, 8'd255);
    it = make_item(OpRecv);
    it.peer_address = '0;
    it.packet_body  = '0;
    pending_items.push_back(it);
    pending_items.push_back(it);            // same key and body: unchanged
    it.peer_address = '1;
    it.packet_body  = '1;
    pending_items.push_back(it);
    it.packet_body  = 64'h5;                 // rewrite
    pending_items.push_back(it);
    it.packet_length = 8'd0;
    pending_items.push_back(it);
    it = make_item(OpRecv);
    it.packet_preamble = ~GoodPreamble;
    pending_items.push_back(it);
    it.packet_preamble = GoodPreamble;
    it.packet_version  = 8'hff;
    pending_items.push_back(it);
    it = make_item(OpMark);
    it.entry_index = 7'd1;
    it.mode_index  = 5'd31;
    it.mark_value  = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(it);             // same
    it.mode_index = 5'd0;
    pending_items.push_back(it);
    it.mark_value = 1'b0;
    pending_items.push_back(it);
    it = make_item(OpRead);
    it.entry_index = 7'd1;
    it.mode_index  = 5'd31;
    pending_items.push_back(it);
    it.entry_index = 7'd50;
    pending_items.push_back(it);
    it = make_item(OpRecv);
    it.peer_address = '1;                    // rewrite because mask is nonzero
    pending_items.push_back(it);
    drain(150);

    // fill with no marks so a full table drops, then marks let evictions through
    write_reg(CfgLength, 8'd0);
    for (int i = 0; i < int'(Limit) + 3; i++) begin
      it = make_item(OpRecv);
      it.peer_address = 48'(rand64());
      pending_items.push_back(it);
    end
    // receiver holds off while the sender keeps offering
    hold_off = 3000;
    drain(150);

    write_reg(CfgLength, 8'($urandom));
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 58;
        recv_idle_pct = 18;
        write_reg(CfgEnable, 8'd0);
        write_reg(CfgLength, 8'd0);
        for (int i = 0; i < 40; i++) pending_items.push_back(make_random());
        drain(150);
        write_reg(CfgEnable, 8'd1);
      end
      if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CfgLength, 8'd255);
      end
      for (int i = 0; i < 520; i++) pending_items.push_back(make_random());
      drain(150);
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/prt_pkg.sv
design/prt_ctrl.sv
design/prt_dpath.sv
design/peer_record_table_with_usage_eviction_core.sv
design/prt_checker.sv
bench/tb_peer_record_table_with_usage_eviction_core.sv
